// ===== sv/kvp_pkg.sv =====
// Shared types and constants of the key-value packet stream parser.
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

    localparam logic [15:0] HDR_LEN     = 16'd4;
    localparam logic [15:0] MIN_SIZE    = 16'd6;
    localparam logic [15:0] MAX_SIZE_RST = 16'hFFFF;
    localparam logic [7:0]  ASCII_SPACE = 8'h20;
    localparam logic [7:0]  ASCII_NL    = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADHEX  = 3'd1,
        ST_SMALL   = 3'd2,
        ST_LIMIT   = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_NOSPACE = 3'd5,
        ST_NONL    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DROP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } kvp_in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] packet_size;
        logic [15:0] key_len;
        logic [15:0] value_len;
    } kvp_out_t;

    typedef struct packed {
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_space;
        logic       is_nl;
        logic       last;
    } kvp_cls_t;

endpackage

`default_nettype wire

// ===== sv/kvp_front.sv =====
// Front end: accepts input words and classifies each byte for the back end.
`timescale 1ns / 1ps
`default_nettype none

module kvp_front (
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire kvp_pkg::kvp_in_t in_word,
    input  wire logic             q_full,
    output logic                  q_push,
    output kvp_pkg::kvp_cls_t     q_word
);

    logic [7:0] b;
    logic       is_digit;
    logic       is_lower;

    always_comb
    begin
        b        = in_word.data_byte;
        is_digit = (b >= 8'h30) && (b <= 8'h39);
        is_lower = (b >= 8'h61) && (b <= 8'h66);

        q_word.hex_ok   = is_digit || is_lower;
        q_word.hex_val  = is_digit ? b[3:0] : 4'(b[3:0] + 4'd9);
        q_word.is_space = (b == kvp_pkg::ASCII_SPACE);
        q_word.is_nl    = (b == kvp_pkg::ASCII_NL);
        q_word.last     = in_word.buffer_end;

        in_stall = q_full;
        q_push   = in_valid && !q_full;
    end

endmodule

`default_nettype wire

// ===== sv/kvp_queue.sv =====
// Short queue of classified words between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module kvp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kvp_pkg::kvp_cls_t push_word,
    input  wire logic              pop,
    output kvp_pkg::kvp_cls_t      head_word,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kvp_pkg::kvp_cls_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        empty     = (count_reg == '0);
        head_word = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("Queue popped while empty.");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("Queue pushed while full.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds the depth.");

endmodule

`default_nettype wire

// ===== sv/kvp_back.sv =====
// Back end: packet state machine, size register and registered result word.
`timescale 1ns / 1ps
`default_nettype none

module kvp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              q_empty,
    input  wire kvp_pkg::kvp_cls_t q_word,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output kvp_pkg::kvp_out_t      out_word
);

    kvp_pkg::phase_t   phase_reg;
    kvp_pkg::phase_t   phase_next;
    logic [1:0]        digit_cnt_reg;
    logic [1:0]        digit_cnt_next;
    logic [15:0]       size_reg;
    logic [15:0]       size_next;
    logic [15:0]       byte_cnt_reg;
    logic [15:0]       byte_cnt_next;
    logic [15:0]       space_off_reg;
    logic [15:0]       space_off_next;
    logic              space_seen_reg;
    logic              space_seen_next;
    logic [15:0]       max_size_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    kvp_pkg::kvp_out_t out_word_reg;
    kvp_pkg::kvp_out_t out_word_next;

    logic              take;
    logic              emit;
    logic              restart;
    logic              to_drop;
    logic [15:0]       bc_inc;
    logic [15:0]       size_new;
    kvp_pkg::kvp_out_t res;

    always_comb
    begin
        take    = !q_empty && (!out_valid_reg || !out_stall);
        q_pop   = take;
        emit    = 1'b0;
        restart = 1'b0;
        to_drop = 1'b0;
        res     = '0;
        bc_inc   = 16'(byte_cnt_reg + 1'b1);
        size_new = {size_reg[11:0], q_word.hex_val};

        phase_next      = phase_reg;
        digit_cnt_next  = digit_cnt_reg;
        size_next       = size_reg;
        byte_cnt_next   = byte_cnt_reg;
        space_off_next  = space_off_reg;
        space_seen_next = space_seen_reg;

        if (take)
        begin
            unique case (phase_reg)
                kvp_pkg::PH_DROP:
                begin
                    restart = q_word.last;
                end
                kvp_pkg::PH_BODY:
                begin
                    byte_cnt_next = bc_inc;
                    if (q_word.is_space && !space_seen_reg)
                    begin
                        space_seen_next = 1'b1;
                        space_off_next  = byte_cnt_reg;
                    end
                    if (bc_inc == size_reg)
                    begin
                        emit            = 1'b1;
                        restart         = 1'b1;
                        res.packet_size = size_reg;
                        if (!q_word.is_nl)
                        begin
                            res.status = kvp_pkg::ST_NONL;
                        end
                        else if (!space_seen_reg)
                        begin
                            res.status = kvp_pkg::ST_NOSPACE;
                        end
                        else
                        begin
                            res.status    = kvp_pkg::ST_OK;
                            res.key_len   = 16'(space_off_reg - kvp_pkg::HDR_LEN);
                            res.value_len = 16'(size_reg - space_off_reg
                                                - (kvp_pkg::MIN_SIZE - kvp_pkg::HDR_LEN));
                        end
                    end
                    else if (q_word.last)
                    begin
                        emit            = 1'b1;
                        restart         = 1'b1;
                        res.status      = kvp_pkg::ST_TRUNC;
                        res.packet_size = size_reg;
                    end
                end
                default:
                begin
                    if (!q_word.hex_ok)
                    begin
                        emit       = 1'b1;
                        restart    = 1'b1;
                        to_drop    = !q_word.last;
                        res.status = kvp_pkg::ST_BADHEX;
                    end
                    else if (digit_cnt_reg == 2'd3)
                    begin
                        res.packet_size = size_new;
                        if (size_new > max_size_reg)
                        begin
                            emit       = 1'b1;
                            restart    = 1'b1;
                            to_drop    = !q_word.last;
                            res.status = kvp_pkg::ST_LIMIT;
                        end
                        else if (size_new < kvp_pkg::MIN_SIZE)
                        begin
                            emit       = 1'b1;
                            restart    = 1'b1;
                            to_drop    = !q_word.last;
                            res.status = kvp_pkg::ST_SMALL;
                        end
                        else if (q_word.last)
                        begin
                            emit       = 1'b1;
                            restart    = 1'b1;
                            res.status = kvp_pkg::ST_TRUNC;
                        end
                        else
                        begin
                            phase_next     = kvp_pkg::PH_BODY;
                            size_next      = size_new;
                            digit_cnt_next = 2'd0;
                            byte_cnt_next  = bc_inc;
                        end
                    end
                    else if (q_word.last)
                    begin
                        emit       = 1'b1;
                        restart    = 1'b1;
                        res.status = kvp_pkg::ST_TRUNC;
                    end
                    else
                    begin
                        size_next      = size_new;
                        digit_cnt_next = 2'(digit_cnt_reg + 1'b1);
                        byte_cnt_next  = bc_inc;
                    end
                end
            endcase
        end

        if (restart)
        begin
            phase_next      = to_drop ? kvp_pkg::PH_DROP : kvp_pkg::PH_HEADER;
            digit_cnt_next  = 2'd0;
            size_next       = '0;
            byte_cnt_next   = '0;
            space_off_next  = '0;
            space_seen_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
            out_word_next  = out_word_reg;
        end

        out_valid = out_valid_reg;
        out_word  = out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= kvp_pkg::PH_HEADER;
            digit_cnt_reg  <= '0;
            size_reg       <= '0;
            byte_cnt_reg   <= '0;
            space_off_reg  <= '0;
            space_seen_reg <= 1'b0;
            max_size_reg   <= kvp_pkg::MAX_SIZE_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            digit_cnt_reg  <= digit_cnt_next;
            size_reg       <= size_next;
            byte_cnt_reg   <= byte_cnt_next;
            space_off_reg  <= space_off_next;
            space_seen_reg <= space_seen_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                max_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    a_body_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == kvp_pkg::PH_BODY) |->
            (digit_cnt_reg == 2'd0) && (byte_cnt_reg >= kvp_pkg::HDR_LEN)
            && (byte_cnt_reg < size_reg))
        else $error("Body byte count outside the declared packet.");

    a_ok_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.status == kvp_pkg::ST_OK)) |->
            (16'(out_word_reg.key_len + out_word_reg.value_len + kvp_pkg::MIN_SIZE)
             == out_word_reg.packet_size))
        else $error("Key and value lengths do not add up to the packet size.");

    a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !q_pop)
        else $error("Word taken from the queue while the result word is blocked.");

endmodule

`default_nettype wire

// ===== sv/kv_packet_stream_parser.sv =====
// Top level of the key-value packet stream parser.
//
// Input words carry one byte of a serialized buffer and a buffer-end mark.
// Each packet is four lower-case hex digits of total length, then key,
// space, value and a newline. One result word leaves per packet: status,
// decoded size, key length and value length; a header error gives one
// result and the rest of the buffer is dropped up to the buffer-end byte.
// Both channels use valid and stall. A byte is accepted each cycle while
// the classified-byte queue has room; the back end retires one queued byte
// per cycle unless a stalled result word blocks it, so throughput is one
// byte per clock. The accepting edge writes a byte into the queue; the
// result register is written when the back end takes that byte from the
// queue head. When the receiver stalls a waiting result word, the word
// holds and the back end stops; the queue of QUEUE_DEPTH entries fills and
// then the input is stalled.
// Reset clears the queue, the packet state and the output valid, and sets
// max_size to 65535. cfg_we writes max_size; the user must write it only
// while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module kv_packet_stream_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire kvp_pkg::kvp_in_t  in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output kvp_pkg::kvp_out_t      out_word,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data
);

    kvp_pkg::kvp_cls_t push_word;
    kvp_pkg::kvp_cls_t head_word;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    kvp_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    kvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .pop       (q_pop),
        .head_word (head_word),
        .full      (q_full),
        .empty     (q_empty)
    );

    kvp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_word    (head_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire
